>>> design/qmb_pkg.sv
// shared types, constants and helpers for the queue with move-behind-match
// no dependencies; imported by queue_move_behind_first_match and qmb_ctrl
package qmb_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;

    localparam int IN_TDATA_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MOVE   = 2'd3;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] popped_value;
        logic [CNT_W-1:0]              entry_count;
        logic [STATUS_W-1:0]           status;
    } t_result;

    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        logic [VALUE_WIDTH-1:0] wr_data;
        logic                   rd_en;
        logic [ADDR_W-1:0]      rd_addr;
    } t_mem_req;

    // queue position to physical slot, wrapping at DEPTH
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [ADDR_W-1:0] pos);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> design/queue_move_behind_first_match.sv
// Bounded queue of 64 signed 32-bit values with push, pop and a move item that
// takes the first match of value_b after the first match of value_a and puts it
// right behind that anchor, shifting the entries in between back by one.
// Input stream: s_axis_tuser carries the kind, s_axis_tdata value_a and value_b.
// Output stream: one result per item with the popped value, the entry count
// after the item and a status code (done, pop on empty, push on full, no move).
// Push and unused kinds go straight to the result, pop first reads the head entry
// from the ram, and a move scans the entries from the head for the anchor and the
// match, then shifts the entries in between one by one and writes the moved value
// right behind the anchor.
// The scan and the shift both run through the single read port of the entry
// ram, one entry per cycle, and items are worked one at a time.
// The next item is accepted as soon as the result sits in the output register,
// so a stalled receiver holds back at most one further result.
// Synchronous active-low reset empties the queue; stored values are not cleared.
// depends on qmb_pkg, qmb_ctrl and qmb_ram
module queue_move_behind_first_match (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [qmb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value_a, value_b
    input  logic [qmb_pkg::KIND_W-1:0]      s_axis_tuser,  // kind
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [qmb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // popped_value, entry_count, zero pad
    output logic [qmb_pkg::STATUS_W-1:0]    m_axis_tuser   // status
);
    import qmb_pkg::*;

    t_result                r_out;
    logic                   r_out_valid;
    t_result                res;
    logic                   res_valid;
    logic                   res_ready;
    t_mem_req               mem;
    logic [VALUE_WIDTH-1:0] rd_data;

    assign res_ready = !r_out_valid || m_axis_tready;

    qmb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_value_a   ($signed(s_axis_tdata[VALUE_WIDTH-1:0])),
        .i_value_b   ($signed(s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH])),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem       (mem),
        .i_rd_data   (rd_data)
    );

    qmb_ram #(
        .AW (ADDR_W),
        .DW (VALUE_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.entry_count, r_out.popped_value});
    assign m_axis_tuser  = r_out.status;

    // items are worked one at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while the previous one is still in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.entry_count <= FULL_COUNT)
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_PUSH_FULL |-> r_out.entry_count == FULL_COUNT)
        else $error("push refused while queue not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_POP_EMPTY
            |-> r_out.entry_count == '0 && r_out.popped_value == '0)
        else $error("pop on empty reported with entries or data");

endmodule

>>> design/qmb_ram.sv
// simple dual-port ram: one write port, one read port with registered data
// no dependencies
module qmb_ram #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/qmb_ctrl.sv
// sequencer for push, pop and move items; owns head and count, drives the ram
// depends on qmb_pkg
module qmb_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [qmb_pkg::KIND_W-1:0]            i_kind,
    input  logic signed [qmb_pkg::VALUE_WIDTH-1:0] i_value_a,
    input  logic signed [qmb_pkg::VALUE_WIDTH-1:0] i_value_b,
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output qmb_pkg::t_result                      o_res,
    output qmb_pkg::t_mem_req                     o_mem,
    input  logic [qmb_pkg::VALUE_WIDTH-1:0]       i_rd_data
);
    import qmb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_RESP
    } t_state;

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_head;
    logic [CNT_W-1:0]        r_count;
    logic signed [VALUE_WIDTH-1:0] r_a;
    logic signed [VALUE_WIDTH-1:0] r_b;
    logic signed [VALUE_WIDTH-1:0] r_popped;
    logic [STATUS_W-1:0]     r_status;
    logic [CNT_W-1:0]        r_pos;
    logic                    r_cmp_vld;
    logic [ADDR_W-1:0]       r_cmp_pos;
    logic                    r_found_a;
    logic [ADDR_W-1:0]       r_ia;
    logic [ADDR_W-1:0]       r_src;
    logic                    r_wr_vld;
    logic [ADDR_W-1:0]       r_wr_pos;

    logic accept;
    logic scan_issue;
    logic shift_issue;
    logic hit_a;
    logic hit_b;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign scan_issue  = (r_pos < r_count);
    assign shift_issue = (r_src > r_ia);
    assign hit_a       = r_cmp_vld && !r_found_a && ($signed(i_rd_data) == r_a);
    assign hit_b       = r_cmp_vld && r_found_a && ($signed(i_rd_data) == r_b);

    always_comb begin
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = phys(r_head, r_wr_pos);
        o_mem.wr_data = i_rd_data;
        o_mem.rd_en   = 1'b0;
        o_mem.rd_addr = phys(r_head, r_pos[ADDR_W-1:0]);
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_kind == KIND_PUSH && r_count < FULL_COUNT) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = phys(r_head, r_count[ADDR_W-1:0]);
                    o_mem.wr_data = i_value_a;
                end
                if (accept && i_kind == KIND_POP && r_count != '0) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_head;
                end
            end
            S_SCAN: begin
                o_mem.rd_en = scan_issue;
            end
            S_SHIFT: begin
                // read one slot toward the anchor while writing the previous one back
                o_mem.wr_en   = r_wr_vld;
                o_mem.rd_en   = shift_issue;
                o_mem.rd_addr = phys(r_head, r_src);
            end
            S_PLACE: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = phys(r_head, r_ia + ADDR_W'(1));
                o_mem.wr_data = r_b;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_found_a <= 1'b0;
            r_wr_vld  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a       <= i_value_a;
                        r_b       <= i_value_b;
                        r_popped  <= '0;
                        r_status  <= ST_DONE;
                        r_pos     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found_a <= 1'b0;
                        r_wr_vld  <= 1'b0;
                        r_state   <= S_RESP;
                        unique case (i_kind)
                            KIND_PUSH: begin
                                if (r_count < FULL_COUNT) begin
                                    r_count <= r_count + CNT_W'(1);
                                end else begin
                                    r_status <= ST_PUSH_FULL;
                                end
                            end
                            KIND_POP: begin
                                if (r_count != '0) begin
                                    r_state <= S_POP;
                                end else begin
                                    r_status <= ST_POP_EMPTY;
                                end
                            end
                            KIND_MOVE: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_popped <= $signed(i_rd_data);
                    r_head   <= phys(r_head, ADDR_W'(1));
                    r_count  <= r_count - CNT_W'(1);
                    r_state  <= S_RESP;
                end
                S_SCAN: begin
                    // one read issued per cycle while entries remain, each compared when its data returns
                    if (scan_issue) begin
                        r_pos     <= r_pos + CNT_W'(1);
                        r_cmp_pos <= r_pos[ADDR_W-1:0];
                    end
                    r_cmp_vld <= scan_issue;
                    if (hit_a) begin
                        r_found_a <= 1'b1;
                        r_ia      <= r_cmp_pos;
                    end
                    if (hit_b) begin
                        if (r_cmp_pos == r_ia + ADDR_W'(1)) begin
                            r_status <= ST_NO_MOVE;
                            r_state  <= S_RESP;
                        end else begin
                            r_src    <= r_cmp_pos - ADDR_W'(1);
                            r_wr_vld <= 1'b0;
                            r_state  <= S_SHIFT;
                        end
                    end else if (!r_cmp_vld && !scan_issue) begin
                        r_status <= ST_NO_MOVE;
                        r_state  <= S_RESP;
                    end
                end
                S_SHIFT: begin
                    if (shift_issue) begin
                        r_wr_vld <= 1'b1;
                        r_wr_pos <= r_src + ADDR_W'(1);
                        r_src    <= r_src - ADDR_W'(1);
                    end else begin
                        r_wr_vld <= 1'b0;
                        r_state  <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid        = (r_state == S_RESP);
    assign o_res.popped_value = r_popped;
    assign o_res.entry_count  = r_count;
    assign o_res.status       = r_status;

endmodule
